### hw/rtl/scs_pkg.sv
// scs_pkg: shared types and codes for the sparse coordinate store
// used by scs_ctrl, scs_datapath and sparse_coordinate_store
`default_nettype none

package scs_pkg;

    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 2;

    localparam logic [OP_BITS-1:0] OP_READ    = 2'd0;
    localparam logic [OP_BITS-1:0] OP_CHECKED = 2'd1;
    localparam logic [OP_BITS-1:0] OP_WRITE   = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } scs_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_last;
    } scs_sts_t;

endpackage

`default_nettype wire

### hw/rtl/sparse_coordinate_store.sv
// sparse_coordinate_store: top level, bound registers on the apb port
// depends on scs_pkg, scs_ctrl and scs_datapath
//
// fixed-capacity coordinate-list store for a sparse integer matrix
// command channel: a word (op, row, col, value) is taken at the clock edge
// where start is high and busy is low; op read, checked read or write cell
// result channel: done is high for exactly one cycle with read_value, found
// and status; the receiver cannot hold results off, one result per word
// each word scans every entry slot through one registered memory read port,
// one slot a cycle, then commits; the result appears in the cycle in which busy
// drops, so the next word can be taken at the edge that ends it; no word is
// taken before the last one has given its result
// writing zero frees the matching slot, a non-zero value updates the match or
// fills the lowest free slot; status reports table full when none is left
// a checked read compares row and col against rows_in_use and cols_in_use,
// written through apb at offset 0 and 4 (0 and 8 for wide indices)
// reset clears all valid bits and both bounds; the entry memory is not cleared
// and needs no clearing pass, so a word can be taken right after reset
`default_nettype none

module sparse_coordinate_store
    import scs_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int INDEX_BITS = 16,
    parameter int VALUE_BITS = 32,
    localparam int BOUND_BITS = INDEX_BITS + 1,
    localparam int DATA_BITS  = (BOUND_BITS > 32) ? 64 : 32,
    localparam int ADDR_BITS  = (BOUND_BITS > 32) ? 4 : 3
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [OP_BITS-1:0]           op,
    input  wire logic [INDEX_BITS-1:0]        row,
    input  wire logic [INDEX_BITS-1:0]        col,
    input  wire logic signed [VALUE_BITS-1:0] value,
    output logic                              done,
    output logic signed [VALUE_BITS-1:0]      read_value,
    output logic                              found,
    output logic [STATUS_BITS-1:0]            status,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ADDR_BITS-1:0]         paddr,
    input  wire logic [DATA_BITS-1:0]         pwdata,
    output logic [DATA_BITS-1:0]              prdata,
    output logic                              pready
);

    logic [BOUND_BITS-1:0] rows_reg;
    logic [BOUND_BITS-1:0] cols_reg;
    logic                  cfg_wr;
    logic                  reg_sel;
    scs_cmd_t              cmd;
    scs_sts_t              sts;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    // top address bit picks the register
    assign reg_sel = paddr[ADDR_BITS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '0;
            cols_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (reg_sel)
            begin
                cols_reg <= pwdata[BOUND_BITS-1:0];
            end
            else
            begin
                rows_reg <= pwdata[BOUND_BITS-1:0];
            end
        end
    end

    assign prdata = reg_sel ? DATA_BITS'(cols_reg) : DATA_BITS'(rows_reg);

    scs_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    scs_datapath
    #(
        .CAPACITY   (CAPACITY),
        .INDEX_BITS (INDEX_BITS),
        .VALUE_BITS (VALUE_BITS),
        .BOUND_BITS (BOUND_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .op          (op),
        .row         (row),
        .col         (col),
        .value       (value),
        .rows_in_use (rows_reg),
        .cols_in_use (cols_reg),
        .done        (done),
        .read_value  (read_value),
        .found       (found),
        .status      (status)
    );

endmodule

`default_nettype wire

### hw/rtl/scs_ctrl.sv
// scs_ctrl: sequencer for one item: accept, slot scan, drain, commit
// depends on scs_pkg
`default_nettype none

module scs_ctrl
    import scs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire scs_sts_t sts,
    output scs_cmd_t      cmd,
    output logic          busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            // last slot is compared here
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

### hw/rtl/scs_datapath.sv
// scs_datapath: entry memory, valid bits, slot scan compare and result registers
// depends on scs_pkg; driven by scs_ctrl
`default_nettype none

module scs_datapath
    import scs_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int INDEX_BITS = 16,
    parameter int VALUE_BITS = 32,
    parameter int BOUND_BITS = INDEX_BITS + 1
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire scs_cmd_t                     cmd,
    output scs_sts_t                          sts,
    input  wire logic [OP_BITS-1:0]           op,
    input  wire logic [INDEX_BITS-1:0]        row,
    input  wire logic [INDEX_BITS-1:0]        col,
    input  wire logic signed [VALUE_BITS-1:0] value,
    input  wire logic [BOUND_BITS-1:0]        rows_in_use,
    input  wire logic [BOUND_BITS-1:0]        cols_in_use,
    output logic                              done,
    output logic signed [VALUE_BITS-1:0]      read_value,
    output logic                              found,
    output logic [STATUS_BITS-1:0]            status
);

    localparam int SLOT_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(CAPACITY - 1);

    // entry memory, one write and one registered read port
    logic [INDEX_BITS-1:0] mem_row [CAPACITY];
    logic [INDEX_BITS-1:0] mem_col [CAPACITY];
    logic [VALUE_BITS-1:0] mem_val [CAPACITY];
    logic [CAPACITY-1:0]   valid_reg;

    logic [OP_BITS-1:0]    op_reg;
    logic [INDEX_BITS-1:0] row_reg;
    logic [INDEX_BITS-1:0] col_reg;
    logic [VALUE_BITS-1:0] val_reg;

    logic [SLOT_BITS-1:0]  scan_idx_reg;
    logic                  rd_vld_reg;
    logic                  rd_bit_reg;
    logic [SLOT_BITS-1:0]  rd_idx_reg;
    logic [INDEX_BITS-1:0] rd_row_reg;
    logic [INDEX_BITS-1:0] rd_col_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;

    logic                  hit_reg;
    logic [SLOT_BITS-1:0]  hit_idx_reg;
    logic [VALUE_BITS-1:0] hit_val_reg;
    logic                  free_reg;
    logic [SLOT_BITS-1:0]  free_idx_reg;

    logic                  done_reg;
    logic [VALUE_BITS-1:0] rv_reg;
    logic                  found_reg;
    logic [STATUS_BITS-1:0] status_reg;

    logic                  is_write;
    logic                  val_zero;
    logic                  past_bound;
    logic                  wr_entry;
    logic                  wr_value;
    logic                  clr_valid;
    logic [SLOT_BITS-1:0]  wr_addr;
    logic [VALUE_BITS-1:0] rv_next;
    logic [STATUS_BITS-1:0] status_next;

    assign sts.scan_last = (scan_idx_reg == LAST_SLOT);

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            row_reg <= row;
            col_reg <= col;
            val_reg <= value;
        end
    end

    // scan address and registered memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan;
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            rd_row_reg <= mem_row[scan_idx_reg];
            rd_col_reg <= mem_col[scan_idx_reg];
            rd_val_reg <= mem_val[scan_idx_reg];
            rd_bit_reg <= valid_reg[scan_idx_reg];
            rd_idx_reg <= scan_idx_reg;
        end
    end

    // keep the first match and the first free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (rd_bit_reg && !hit_reg && rd_row_reg == row_reg && rd_col_reg == col_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (!rd_bit_reg && !free_reg)
            begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            if (rd_bit_reg && !hit_reg && rd_row_reg == row_reg && rd_col_reg == col_reg)
            begin
                hit_idx_reg <= rd_idx_reg;
                hit_val_reg <= rd_val_reg;
            end
            if (!rd_bit_reg && !free_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
        end
    end

    // commit decision
    always_comb
    begin
        is_write     = (op_reg == OP_WRITE);
        val_zero     = (val_reg == '0);
        past_bound   = ({1'b0, row_reg} >= rows_in_use) || ({1'b0, col_reg} >= cols_in_use);
        wr_entry     = 1'b0;
        wr_value     = 1'b0;
        clr_valid    = 1'b0;
        wr_addr      = hit_reg ? hit_idx_reg : free_idx_reg;
        rv_next      = '0;
        status_next  = ST_OK;
        if (is_write)
        begin
            if (val_zero)
            begin
                clr_valid = hit_reg;
            end
            else if (hit_reg)
            begin
                wr_value = 1'b1;
            end
            else if (free_reg)
            begin
                wr_entry = 1'b1;
                wr_value = 1'b1;
            end
            else
            begin
                status_next = ST_FULL;
            end
        end
        else if (op_reg == OP_CHECKED && past_bound)
        begin
            status_next = ST_RANGE;
        end
        else if (hit_reg)
        begin
            rv_next = hit_val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_entry)
        begin
            mem_row[wr_addr] <= row_reg;
            mem_col[wr_addr] <= col_reg;
        end
        if (cmd.commit && wr_value)
        begin
            mem_val[wr_addr] <= val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (wr_entry)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            else if (clr_valid)
            begin
                valid_reg[wr_addr] <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rv_reg     <= rv_next;
            found_reg  <= hit_reg;
            status_reg <= status_next;
        end
    end

    assign done       = done_reg;
    assign read_value = rv_reg;
    assign found      = found_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

### tb/sparse_coordinate_store_tb.sv
// sparse_coordinate_store_tb: self-checking bench for the sparse coordinate store
// drives command words and apb bound writes, checks each result against a local model
// depends on scs_pkg and sparse_coordinate_store
module sparse_coordinate_store_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scs_pkg::*;

    localparam int SLOTS        = 64;
    localparam int ROUND_CYCLES = SLOTS + 3;
    localparam int POOL         = 96;
    localparam int PHASES       = 6;
    localparam int MIX_ITEMS    = 160;
    localparam int PROBES       = 24;

    // unused selector, the block treats it as a plain read
    localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;

    localparam logic [2:0] ADDR_ROWS = 3'd0;
    localparam logic [2:0] ADDR_COLS = 3'd4;

    localparam int GAP_NONE   = 0;
    localparam int GAP_ACCEPT = 1;
    localparam int GAP_IDLE   = 2;

    typedef struct packed {
        logic signed [31:0]       read_value;
        logic                     found;
        logic [STATUS_BITS-1:0]   status;
    } cell_answer_t;

    typedef struct packed {
        logic [OP_BITS-1:0]       op;
        logic [15:0]              row;
        logic [15:0]              col;
        logic [31:0]              value;
        logic                     fixed;
        logic [31:0]              want_value;
        logic                     want_found;
        logic [STATUS_BITS-1:0]   want_status;
    } probe_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [OP_BITS-1:0]           op;
    logic [15:0]                  row;
    logic [15:0]                  col;
    logic signed [31:0]           value;
    logic                         done;
    logic signed [31:0]           read_value;
    logic                         found;
    logic [STATUS_BITS-1:0]       status;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [2:0]                   paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    // local copy of the coordinate list and the bounds
    logic [15:0]                  slot_row [SLOTS];
    logic [15:0]                  slot_col [SLOTS];
    logic [31:0]                  slot_value [SLOTS];
    logic                         slot_used [SLOTS];
    logic [16:0]                  bound_rows;
    logic [16:0]                  bound_cols;

    cell_answer_t                 answer_q [$];
    int                           errors;
    int                           gap_style;

    logic [15:0]                  pool_row [POOL];
    logic [15:0]                  pool_col [POOL];

    // bounds are 0 here, so every checked read is out of range
    probe_t probes [PROBES] = '{
        '{OP_READ,    16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, ST_OK},
        '{OP_CHECKED, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, ST_RANGE},
        '{OP_WRITE,   16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, ST_OK},
        '{OP_WRITE,   16'h0000, 16'h0000, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 1'b0, ST_OK},
        '{OP_READ,    16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1, ST_OK},
        '{OP_WRITE,   16'hFFFF, 16'hFFFF, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b0, ST_OK},
        '{OP_READ,    16'hFFFF, 16'hFFFF, 32'h0000_0000, 1'b1, 32'h8000_0000, 1'b1, ST_OK},
        '{OP_SPARE,   16'hFFFF, 16'hFFFF, 32'h1234_5678, 1'b1, 32'h8000_0000, 1'b1, ST_OK},
        '{OP_CHECKED, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, ST_RANGE},
        '{OP_WRITE,   16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1, ST_OK},
        '{OP_READ,    16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_OK},
        '{OP_WRITE,   16'h0000, 16'hFFFF, 32'h0000_0001, 1'b0, 32'h0, 1'b0, ST_OK},
        '{OP_WRITE,   16'hFFFF, 16'h0000, 32'h55AA_55AA, 1'b0, 32'h0, 1'b0, ST_OK},
        '{OP_READ,    16'h0000, 16'hFFFF, 32'h0000_0000, 1'b0, 32'h0, 1'b0, ST_OK},
        '{OP_READ,    16'hFFFF, 16'h0000, 32'hA5A5_A5A5, 1'b0, 32'h0, 1'b0, ST_OK},
        '{OP_SPARE,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0, ST_OK},
        '{OP_WRITE,   16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, ST_OK},
        '{OP_READ,    16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, ST_OK},
        '{OP_WRITE,   16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, ST_OK},
        '{OP_WRITE,   16'h5555, 16'hAAAA, 32'h0000_0001, 1'b0, 32'h0, 1'b0, ST_OK},
        '{OP_READ,    16'hAAAA, 16'h5555, 32'h0000_0000, 1'b0, 32'h0, 1'b0, ST_OK},
        '{OP_CHECKED, 16'h5555, 16'hAAAA, 32'h0000_0000, 1'b0, 32'h0, 1'b0, ST_OK},
        '{OP_WRITE,   16'hFFFF, 16'hFFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, ST_OK},
        '{OP_READ,    16'hFFFF, 16'hFFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, ST_OK}
    };

    sparse_coordinate_store DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // computes the answer to one word and applies it to the local list
    function automatic cell_answer_t apply_cell_word(logic [OP_BITS-1:0] w_op,
                                                     logic [15:0] w_row,
                                                     logic [15:0] w_col,
                                                     logic [31:0] w_value);
        cell_answer_t ans;
        int           hit_slot;
        int           free_idx;
        int           i;
        hit_slot = -1;
        free_idx = -1;
        for (i = 0; i < SLOTS; i++)
        begin
            if (hit_slot < 0 && slot_used[i] && slot_row[i] == w_row && slot_col[i] == w_col)
                hit_slot = i;
            if (free_idx < 0 && !slot_used[i])
                free_idx = i;
        end
        ans.read_value = '0;
        ans.found      = (hit_slot >= 0);
        ans.status     = ST_OK;
        if (w_op == OP_WRITE)
        begin
            if (w_value == 32'd0)
            begin
                if (hit_slot >= 0)
                    slot_used[hit_slot] = 1'b0;
            end
            else if (hit_slot >= 0)
                slot_value[hit_slot] = w_value;
            else if (free_idx >= 0)
            begin
                slot_row[free_idx]   = w_row;
                slot_col[free_idx]   = w_col;
                slot_value[free_idx] = w_value;
                slot_used[free_idx]  = 1'b1;
            end
            else
                ans.status = ST_FULL;
        end
        else if (w_op == OP_CHECKED &&
                 ({1'b0, w_row} >= bound_rows || {1'b0, w_col} >= bound_cols))
            ans.status = ST_RANGE;
        else if (hit_slot >= 0)
            ans.read_value = slot_value[hit_slot];
        return ans;
    endfunction

    // index biased toward the bound and the field extremes
    function automatic logic [15:0] pick_index(logic [16:0] bound);
        logic [15:0] lim;
        lim = (bound > 17'hFFFF) ? 16'hFFFF : bound[15:0];
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'h0000;
            2: return 16'hFFFF;
            3: return (bound == 17'd0) ? 16'h0000 : 16'(bound - 17'd1);
            default: return 16'($urandom_range(0, 32'(lim)));
        endcase
    endfunction

    task automatic write_bound(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ROWS)
            bound_rows = data[16:0];
        else
            bound_cols = data[16:0];
        @(posedge clk);
    endtask

    task automatic send_word(input logic [OP_BITS-1:0] w_op, input logic [15:0] w_row,
                             input logic [15:0] w_col, input logic [31:0] w_value,
                             input logic use_fixed, input cell_answer_t fixed);
        int           gap;
        cell_answer_t ans;
        gap = (gap_style == GAP_NONE) ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            start <= 1'b0;
            // let the block go idle first so the gap lands after the result
            if (gap_style == GAP_IDLE)
            begin
                @(posedge clk);
                while (busy)
                    @(posedge clk);
            end
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        op    <= w_op;
        row   <= w_row;
        col   <= w_col;
        value <= w_value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ans = apply_cell_word(w_op, w_row, w_col, w_value);
        answer_q = {answer_q, (use_fixed ? fixed : ans)};
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_result
        cell_answer_t want;
        if (rst_n && done)
        begin
            if (answer_q.size() == 0)
            begin
                $display("%0t: unexpected result read_value %0d found %0b status %0d",
                         $time, read_value, found, status);
                errors++;
            end
            else
            begin
                want = answer_q.pop_front();
                if (read_value !== want.read_value)
                begin
                    $display("%0t: read_value expected %0d got %0d",
                             $time, want.read_value, read_value);
                    errors++;
                end
                if (found !== want.found)
                begin
                    $display("%0t: found expected %0b got %0b", $time, want.found, found);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int                 p;
        int                 i;
        int                 k;
        int                 sel;
        logic [15:0]        r;
        logic [15:0]        c;
        logic [31:0]        v;
        logic [OP_BITS-1:0] o;
        logic [16:0]        nr;
        logic [16:0]        nc;
        logic [15:0]        gone_row [$];
        logic [15:0]        gone_col [$];

        errors     = 0;
        gap_style  = GAP_ACCEPT;
        bound_rows = '0;
        bound_cols = '0;
        for (i = 0; i < SLOTS; i++)
            slot_used[i] = 1'b0;
        rst_n   = 1'b0;
        start   = 1'b0;
        op      = OP_READ;
        row     = '0;
        col     = '0;
        value   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[j])
            send_word(probes[j].op, probes[j].row, probes[j].col, probes[j].value,
                      probes[j].fixed,
                      cell_answer_t'{probes[j].want_value, probes[j].want_found,
                                     probes[j].want_status});
        drain_results();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin nr = 17'h10000; nc = 17'h10000; end
                1: begin nr = 17'h1FFFF; nc = 17'h1FFFF; end
                2: begin nr = 17'($urandom_range(1, 300)); nc = 17'($urandom_range(1, 300)); end
                3: begin nr = 17'd1; nc = 17'd1; end
                4: begin nr = 17'd0; nc = 17'h10000; end
                default: begin nr = 17'($urandom); nc = 17'($urandom); end
            endcase
            // junk above bit 16 must be dropped by the register
            write_bound(ADDR_ROWS, {15'($urandom), nr});
            write_bound(ADDR_COLS, {15'($urandom), nc});
            gap_style = p % 3;

            for (i = 0; i < POOL; i++)
            begin
                pool_row[i] = pick_index(bound_rows);
                pool_col[i] = pick_index(bound_cols);
            end

            for (i = 0; i < MIX_ITEMS; i++)
            begin
                if (i == MIX_ITEMS / 2)
                begin
                    if (p % 2 == 0)
                    begin
                        // fresh keys past capacity, ends with table-full answers
                        for (k = 0; k < SLOTS + 6; k++)
                            send_word(OP_WRITE, 16'($urandom), 16'($urandom),
                                      $urandom | 32'h1, 1'b0, '0);
                    end
                    else
                    begin
                        gone_row.delete();
                        gone_col.delete();
                        for (k = 0; k < SLOTS; k++)
                        begin
                            if (slot_used[k] && $urandom_range(0, 1) == 1)
                            begin
                                gone_row = {gone_row, slot_row[k]};
                                gone_col = {gone_col, slot_col[k]};
                            end
                        end
                        foreach (gone_row[j])
                            send_word(OP_WRITE, gone_row[j], gone_col[j], 32'd0, 1'b0, '0);
                    end
                end
                k = $urandom_range(0, POOL - 1);
                if ($urandom_range(0, 9) < 7)
                begin
                    r = pool_row[k];
                    c = pool_col[k];
                end
                else
                begin
                    r = 16'($urandom);
                    c = 16'($urandom);
                end
                sel = $urandom_range(0, 19);
                if (sel < 9)
                    o = OP_WRITE;
                else if (sel < 14)
                    o = OP_READ;
                else if (sel < 19)
                    o = OP_CHECKED;
                else
                    o = OP_SPARE;
                case ($urandom_range(0, 9))
                    0, 1: v = 32'd0;
                    2: v = 32'h8000_0000;
                    3: v = 32'h7FFF_FFFF;
                    default: v = $urandom;
                endcase
                send_word(o, r, c, v, 1'b0, '0);
                if ($urandom_range(0, 39) == 0)
                    drain_results();
            end
            drain_results();
        end

        repeat (ROUND_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
